// ----- rtl/psdm_pkg.sv -----
// Package for the potentiometer smoother with deadband and output mapper.
// Holds field widths, the request and result structs, register indexes and sequencer states.
// No dependencies; every file of the block imports it.
package psdm_pkg;

  // Sizing of the block.
  localparam int unsigned ChannelsDef = 8;
  localparam int unsigned SampleBits  = 12;
  localparam int unsigned ChW         = 3;
  localparam int unsigned SmpW        = 12;
  localparam int unsigned PosW        = 13;
  localparam int unsigned CntW        = 7;
  localparam int unsigned AccW        = 18;
  localparam int unsigned ShiftW      = 4;
  localparam int unsigned DbW         = 8;
  localparam int unsigned SumDbW      = 9;
  // The EMA product and sum wrap at a 32-bit word.
  localparam int unsigned EmaW        = 32;
  localparam int unsigned DivW        = 24;
  localparam int unsigned DivCntW     = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 12;

  // Oversampling limit and output map constants.
  localparam logic [CntW-1:0] OvsMax  = CntW'(64);
  localparam logic [PosW-1:0] MapTop  = PosW'(4097);
  localparam logic [SmpW-1:0] SampleMask =
      (SampleBits >= SmpW) ? {SmpW{1'b1}} : SmpW'((1 << SampleBits) - 1);

  // Register reset values.
  localparam logic [CntW-1:0]   OvsReset        = CntW'(8);
  localparam logic [SmpW-1:0]   ClipLowReset    = SmpW'(0);
  localparam logic [SmpW-1:0]   ClipHighReset   = SmpW'(4095);
  localparam logic [ShiftW-1:0] EmaShiftReset   = ShiftW'(3);
  localparam logic [DbW-1:0]    BaseDbReset     = DbW'(8);
  localparam logic [DbW-1:0]    CenterBonusReset = DbW'(4);
  localparam logic [SmpW-1:0]   CenterBandReset = SmpW'(64);

  // One sample request.
  typedef struct packed {
    logic [ChW-1:0]  channel;
    logic [SmpW-1:0] sample;
  } in_t;

  // One position result.
  typedef struct packed {
    logic [ChW-1:0]  out_channel;
    logic [PosW-1:0] position;
  } out_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_OVERSAMPLE    = 3'd0,
    CFG_CLIP_LOW      = 3'd1,
    CFG_CLIP_HIGH     = 3'd2,
    CFG_EMA_SHIFT     = 3'd3,
    CFG_BASE_DEADBAND = 3'd4,
    CFG_CENTER_BONUS  = 3'd5,
    CFG_CENTER_BAND   = 3'd6
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG_DIV,
    S_EMA_MUL,
    S_EMA_ADD,
    S_SETTLE,
    S_MAP_PREP,
    S_MAP_DIV,
    S_OUT
  } state_e;

endpackage

// ----- rtl/pot_smoother_deadband_mapper.sv -----
// Potentiometer smoother: per-channel oversampling, EMA, hysteresis deadband, inverted map.
// A sample that does not complete an average is absorbed while idle. One that does goes through
// average divide, EMA update (a seed on a channel's first update), map divide (skipped on an
// empty span) and output; the shared restoring divider takes 18 steps for the average, 24 for the
// map. Input stalls until the sequencer is idle again; a held result stalls input only when the
// next result is ready. Reset (async, active low) clears accumulators, flags and sequencer.
module pot_smoother_deadband_mapper import psdm_pkg::*; #(
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [CntW-1:0]   ovs_q;
  logic [SmpW-1:0]   clip_lo_q;
  logic [SmpW-1:0]   clip_hi_q;
  logic [ShiftW-1:0] ema_shift_q;
  logic [DbW-1:0]    base_db_q;
  logic [DbW-1:0]    bonus_q;
  logic [SmpW-1:0]   band_q;

  // Per-channel state.
  logic [AccW-1:0] acc_sum_q [CHANNELS];
  logic [CntW-1:0] acc_cnt_q [CHANNELS];
  logic            seeded_q  [CHANNELS];
  logic [AccW-1:0] ema_q     [CHANNELS];
  logic [SmpW-1:0] stable_q  [CHANNELS];

  // Sequencer and datapath registers.
  state_e             state_q, state_d;
  logic [IdxW-1:0]    ch_q;
  logic [SmpW-1:0]    div_rem_q;
  logic [DivW-1:0]    div_quo_q;
  logic [SmpW-1:0]    div_den_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [EmaW-1:0]    prod_q;
  logic [AccW-1:0]    ema_new_q;
  logic [SmpW-1:0]    st_q;
  logic               zero_span_q;
  logic               out_valid_q;
  out_t               out_data_q;

  // Combinational signals.
  logic               in_fire, in_range, out_free, acc_done;
  logic [31:0]        in_ch_ext;
  logic [IdxW-1:0]    in_idx;
  logic [SmpW-1:0]    smp;
  logic [CntW-1:0]    n_eff;
  logic [AccW-1:0]    acc_new_sum;
  logic [CntW-1:0]    acc_new_cnt;
  logic               div_load;
  logic [DivW-1:0]    div_num;
  logic [SmpW-1:0]    div_den;
  logic [DivCntW-1:0] div_len;
  logic [SmpW:0]      div_sh, div_diff;
  logic               div_ge;
  logic [AccW-1:0]    avg;
  logic [SmpW-1:0]    avg_clip;
  logic [EmaW-1:0]    ema_sum, ema_shr;
  logic [SmpW:0]      center_sum;
  logic [SmpW-1:0]    center, ctr_dist, st_old;
  logic [SumDbW-1:0]  deadband;
  logic [AccW-1:0]    diff, pick;
  logic [SmpW-1:0]    st_new;
  logic               zero_span;
  logic [SmpW-1:0]    span, norm;
  logic [DivW-1:0]    map_num;

  // Clamp to the clip range; the upper bound is applied last.
  function automatic logic [SmpW-1:0] clip_fn(input logic [AccW-1:0] v,
                                              input logic [SmpW-1:0] lo,
                                              input logic [SmpW-1:0] hi);
    logic [AccW-1:0] r;
    r = v;
    if (r < AccW'(lo)) r = AccW'(lo);
    if (r > AccW'(hi)) r = AccW'(hi);
    return r[SmpW-1:0];
  endfunction

  // Handshakes.
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovs_q       <= OvsReset;
      clip_lo_q   <= ClipLowReset;
      clip_hi_q   <= ClipHighReset;
      ema_shift_q <= EmaShiftReset;
      base_db_q   <= BaseDbReset;
      bonus_q     <= CenterBonusReset;
      band_q      <= CenterBandReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OVERSAMPLE:    ovs_q       <= cfg_data_i[CntW-1:0];
        CFG_CLIP_LOW:      clip_lo_q   <= cfg_data_i[SmpW-1:0];
        CFG_CLIP_HIGH:     clip_hi_q   <= cfg_data_i[SmpW-1:0];
        CFG_EMA_SHIFT:     ema_shift_q <= cfg_data_i[ShiftW-1:0];
        CFG_BASE_DEADBAND: base_db_q   <= cfg_data_i[DbW-1:0];
        CFG_CENTER_BONUS:  bonus_q     <= cfg_data_i[DbW-1:0];
        CFG_CENTER_BAND:   band_q      <= cfg_data_i[SmpW-1:0];
        default: ;
      endcase
    end
  end

  // Accumulation of the incoming sample.
  always_comb begin
    in_ch_ext   = {{(32-ChW){1'b0}}, in_data_i.channel};
    in_range    = (in_ch_ext < CHANNELS);
    in_idx      = in_ch_ext[IdxW-1:0];
    smp         = in_data_i.sample & SampleMask;
    if (ovs_q == '0) begin
      n_eff = CntW'(1);
    end else if (ovs_q > OvsMax) begin
      n_eff = OvsMax;
    end else begin
      n_eff = ovs_q;
    end
    acc_new_sum = acc_sum_q[in_idx] + AccW'(smp);
    acc_new_cnt = acc_cnt_q[in_idx] + CntW'(1);
    acc_done    = (acc_new_cnt >= n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_sum_q[i] <= '0;
        acc_cnt_q[i] <= '0;
      end
    end else if (in_fire && in_range) begin
      acc_sum_q[in_idx] <= acc_done ? '0 : acc_new_sum;
      acc_cnt_q[in_idx] <= acc_done ? '0 : acc_new_cnt;
    end
  end

  // Shared restoring divider step: one quotient bit per cycle.
  always_comb begin
    div_sh   = {div_rem_q, div_quo_q[DivW-1]};
    div_diff = div_sh - {1'b0, div_den_q};
    div_ge   = (div_sh >= {1'b0, div_den_q});
  end

  // EMA, deadband, clipping and map arithmetic.
  always_comb begin
    avg        = div_quo_q[AccW-1:0];
    avg_clip   = clip_fn(avg, clip_lo_q, clip_hi_q);
    ema_sum    = prod_q + EmaW'(avg);
    ema_shr    = ema_sum >> ema_shift_q;
    st_old     = stable_q[ch_q];
    center_sum = {1'b0, clip_lo_q} + {1'b0, clip_hi_q};
    center     = center_sum[SmpW:1];
    ctr_dist   = (st_old > center) ? (st_old - center) : (center - st_old);
    deadband   = SumDbW'(base_db_q) + ((ctr_dist <= band_q) ? SumDbW'(bonus_q) : '0);
    diff       = (ema_new_q > AccW'(st_old)) ? (ema_new_q - AccW'(st_old))
                                             : (AccW'(st_old) - ema_new_q);
    pick       = (diff >= AccW'(deadband)) ? ema_new_q : AccW'(st_old);
    st_new     = clip_fn(pick, clip_lo_q, clip_hi_q);
    zero_span  = (clip_hi_q <= clip_lo_q);
    span       = clip_hi_q - clip_lo_q;
    norm       = st_q - clip_lo_q;
    map_num    = {norm, {SmpW{1'b0}}} - DivW'(norm) + DivW'(span[SmpW-1:1]);
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and divider load.
  always_comb begin
    state_d  = state_q;
    div_load = 1'b0;
    div_num  = '0;
    div_den  = '0;
    div_len  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && in_range && acc_done) begin
          div_load = 1'b1;
          div_num  = {acc_new_sum, {(DivW-AccW){1'b0}}};
          div_den  = SmpW'(n_eff);
          div_len  = DivCntW'(AccW);
          state_d  = S_AVG_DIV;
        end
      end
      S_AVG_DIV: begin
        if (div_cnt_q == DivCntW'(1)) state_d = S_EMA_MUL;
      end
      S_EMA_MUL: begin
        state_d = seeded_q[ch_q] ? S_EMA_ADD : S_MAP_PREP;
      end
      S_EMA_ADD: begin
        state_d = S_SETTLE;
      end
      S_SETTLE: begin
        state_d = S_MAP_PREP;
      end
      S_MAP_PREP: begin
        if (zero_span) begin
          state_d = S_OUT;
        end else begin
          div_load = 1'b1;
          div_num  = map_num;
          div_den  = span;
          div_len  = DivCntW'(DivW);
          state_d  = S_MAP_DIV;
        end
      end
      S_MAP_DIV: begin
        if (div_cnt_q == DivCntW'(1)) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Divider step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_load) begin
      div_cnt_q <= div_len;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - DivCntW'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) ch_q <= in_idx;
    if (div_load) begin
      div_rem_q <= '0;
      div_quo_q <= div_num;
      div_den_q <= div_den;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= div_ge ? div_diff[SmpW-1:0] : div_sh[SmpW-1:0];
      div_quo_q <= {div_quo_q[DivW-2:0], div_ge};
    end
    if (state_q == S_EMA_MUL) begin
      prod_q <= (EmaW'(ema_q[ch_q]) << ema_shift_q) - EmaW'(ema_q[ch_q]);
      if (!seeded_q[ch_q]) st_q <= avg_clip;
    end
    if (state_q == S_EMA_ADD) ema_new_q <= ema_shr[AccW-1:0];
    if (state_q == S_SETTLE) st_q <= st_new;
    if (state_q == S_MAP_PREP) zero_span_q <= zero_span;
  end

  // Seeded flags: set on the first completed average of a channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) seeded_q[i] <= 1'b0;
    end else if (state_q == S_EMA_MUL && !seeded_q[ch_q]) begin
      seeded_q[ch_q] <= 1'b1;
    end
  end

  // EMA and stable value store, written on seeding and on each later update.
  always_ff @(posedge clk_i) begin
    if (state_q == S_EMA_MUL && !seeded_q[ch_q]) begin
      ema_q[ch_q]    <= AccW'(avg_clip);
      stable_q[ch_q] <= avg_clip;
    end else if (state_q == S_SETTLE) begin
      ema_q[ch_q]    <= ema_new_q;
      stable_q[ch_q] <= st_new;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_data_q.out_channel <= ChW'(ch_q);
      out_data_q.position    <= zero_span_q ? PosW'(1)
                                            : (MapTop - PosW'(1) - div_quo_q[PosW-1:0]);
    end
  end

  // Checks on the sequencer and datapath.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.position >= PosW'(1) && out_data_o.position <= PosW'(4096)))
    else $error("position out of range");

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AVG_DIV || state_q == S_MAP_DIV) |-> (div_cnt_q != '0))
    else $error("divider idle while sequencer waits on it");

  a_ema_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMA_ADD) |-> seeded_q[ch_q])
    else $error("EMA update on an unseeded channel");

  a_acc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_range) |-> (acc_cnt_q[in_idx] < OvsMax))
    else $error("stored sample count reached the oversampling limit");

endmodule
